### design/size_class_slab_allocator_unit_assert.svh
// Assertion macros for the slab allocator checks.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SCSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// next-cycle implication
`define SCSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

### design/scsa_pkg.sv
// Shared constants, types and helpers for the size-class slab allocator.
// No dependencies.
package scsa_pkg;

  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int CLASSES     = 8;
  localparam int CLS_W       = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int PAGES       = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = $clog2(PAGES);
  localparam int PGF_W       = ADDR_W - PAGE_SHIFT;
  localparam int NEXT_W      = $clog2(PAGES + 1);
  localparam int MIN_SHIFT   = 3;
  localparam int LINK_AW     = ADDR_W - MIN_SHIFT;
  localparam int LINK_DEPTH  = 2 ** LINK_AW;
  localparam int LEFT_W      = PAGE_SHIFT - MIN_SHIFT;
  localparam int OWNER_W     = 4;
  localparam logic [OWNER_W-1:0] OWNER_NONE = 4'd15;
  localparam int ADDR_PAGES  = (2 ** ADDR_W) / PAGE_BYTES;
  localparam int PAGE_LIMIT  = (PAGES < ADDR_PAGES) ? PAGES : ADDR_PAGES;
  localparam int MAX_BLOCK   = 1 << (MIN_SHIFT + CLASSES - 1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOC   = 3'd0,
    STATUS_FREED   = 3'd1,
    STATUS_NOPAGE  = 3'd2,
    STATUS_TOOBIG  = 3'd3,
    STATUS_IGNORED = 3'd4
  } status_t;

  // usable slots of a fresh page, header slot excluded
  function automatic logic [LEFT_W-1:0] slots_after_header(input int cls);
    int v;
    v = (PAGE_BYTES >> (MIN_SHIFT + cls)) - 1;
    return v[LEFT_W-1:0];
  endfunction

endpackage

### design/scsa_if.sv
// Request and result channel interfaces of the slab allocator.
// Depends on scsa_pkg.
interface scsa_in_if import scsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;

  modport source(output valid, kind, size, address, input ready);
  modport sink(input valid, kind, size, address, output ready);
endinterface

interface scsa_out_if import scsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address_res;
  logic [STATUS_W-1:0] status;

  modport source(output valid, address_res, status, input ready);
  modport sink(input valid, address_res, status, output ready);
endinterface

### design/size_class_slab_allocator_unit.sv
// Power-of-two size-class slab allocator: top level.
// Depends on scsa_pkg, scsa_if, scsa_ram and the assertion header.
//
//   channel | dir | fields                     | beat when
//   in_ch   | in  | kind, size, address        | valid && ready
//   out_ch  | out | address_res, status        | valid && ready
//
// Each request passes through ST_IDLE, where the accept issues the link and owner
// memory reads, and ST_EXEC, which uses the read data and writes back state.
// A new request is taken once the previous one has finished, even while its
// result still waits in the output register. Reset is synchronous; no
// clearing pass is needed. An output stall holds ST_EXEC.
`include "size_class_slab_allocator_unit_assert.svh"

module size_class_slab_allocator_unit import scsa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  scsa_in_if.sink    in_ch,
  scsa_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic                kind_r;
  logic [CLS_W-1:0]    cls_r;
  logic                too_big_r;
  logic [ADDR_W-1:0]   addr_r;

  logic [ADDR_W-1:0]   head_addr_r  [CLASSES];
  logic [ADDR_W-1:0]   head_addr_nxt[CLASSES];
  logic [CLASSES-1:0]  head_valid_r, head_valid_nxt;
  logic [PAGE_W-1:0]   fresh_page_r  [CLASSES];
  logic [PAGE_W-1:0]   fresh_page_nxt[CLASSES];
  logic [LEFT_W-1:0]   fresh_left_r  [CLASSES];
  logic [LEFT_W-1:0]   fresh_left_nxt[CLASSES];
  logic [NEXT_W-1:0]   next_page_r, next_page_nxt;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                in_fire, exec_fire;
  logic [CLS_W-1:0]    cls_in;
  logic                too_big_in;

  logic                link_we;
  logic [ADDR_W-1:0]   link_wdata;
  logic [ADDR_W-1:0]   link_rdata;
  logic                owner_we;
  logic [OWNER_W-1:0]  owner_rdata;

  logic [PGF_W-1:0]    page_idx;
  logic [OWNER_W-1:0]  owner;
  logic [CLS_W-1:0]    cls_f;
  logic [ADDR_W-1:0]   align_mask;
  logic [LEFT_W-1:0]   slots;
  logic [ADDR_W-1:0]   page_base;
  logic [ADDR_W-1:0]   new_base;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.address_res = out_addr_r;
  assign out_ch.status      = out_status_r;

  // smallest class that holds the requested size
  always_comb begin
    too_big_in = int'(in_ch.size) > MAX_BLOCK;
    cls_in     = CLS_W'(CLASSES - 1);
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (int'(in_ch.size) <= (1 << (MIN_SHIFT + c))) begin
        cls_in = CLS_W'(c);
      end
    end
  end

  scsa_ram #(.WIDTH(ADDR_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (addr_r[ADDR_W-1:MIN_SHIFT]),
    .wr_data (link_wdata),
    .rd_en   (in_fire),
    .rd_addr (head_addr_r[cls_in][ADDR_W-1:MIN_SHIFT]),
    .rd_data (link_rdata)
  );

  scsa_ram #(.WIDTH(OWNER_W), .DEPTH(PAGES)) u_owner_ram (
    .clk     (clk),
    .wr_en   (owner_we),
    .wr_addr (next_page_r[PAGE_W-1:0]),
    .wr_data (OWNER_W'(cls_r)),
    .rd_en   (in_fire),
    .rd_addr (in_ch.address[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT]),
    .rd_data (owner_rdata)
  );

  // pages below the fill mark are owned; the boot pages are never written
  always_comb begin
    page_idx = addr_r[ADDR_W-1:PAGE_SHIFT];
    if (int'(page_idx) < CLASSES) begin
      owner = OWNER_W'(page_idx);
    end else if (int'(page_idx) < int'(next_page_r)) begin
      owner = owner_rdata;
    end else begin
      owner = OWNER_NONE;
    end
    cls_f      = owner[CLS_W-1:0];
    align_mask = ADDR_W'((1 << (MIN_SHIFT + int'(cls_f))) - 1);
    slots      = slots_after_header(int'(cls_r));
    page_base  = ADDR_W'({fresh_page_r[cls_r], {PAGE_SHIFT{1'b0}}});
    new_base   = ADDR_W'({next_page_r[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}});
  end

  always_comb begin
    head_addr_nxt  = head_addr_r;
    head_valid_nxt = head_valid_r;
    fresh_page_nxt = fresh_page_r;
    fresh_left_nxt = fresh_left_r;
    next_page_nxt  = next_page_r;
    link_we        = 1'b0;
    link_wdata     = '0;
    owner_we       = 1'b0;
    out_addr_nxt   = '0;
    out_status_nxt = STATUS_IGNORED;
    if (!kind_r) begin
      priority if (too_big_r) begin
        out_status_nxt = STATUS_TOOBIG;
      end else if (head_valid_r[cls_r]) begin
        out_addr_nxt          = head_addr_r[cls_r];
        out_status_nxt        = STATUS_ALLOC;
        head_addr_nxt[cls_r]  = link_rdata;
        head_valid_nxt[cls_r] = (link_rdata != '0);
      end else if (fresh_left_r[cls_r] == '0) begin
        if (int'(next_page_r) >= PAGE_LIMIT) begin
          out_status_nxt = STATUS_NOPAGE;
        end else begin
          owner_we              = exec_fire;
          fresh_page_nxt[cls_r] = next_page_r[PAGE_W-1:0];
          next_page_nxt         = next_page_r + NEXT_W'(1);
          fresh_left_nxt[cls_r] = slots - LEFT_W'(1);
          out_addr_nxt          = new_base + (ADDR_W'(slots) << (MIN_SHIFT + int'(cls_r)));
          out_status_nxt        = STATUS_ALLOC;
        end
      end else begin
        fresh_left_nxt[cls_r] = fresh_left_r[cls_r] - LEFT_W'(1);
        out_addr_nxt          = page_base
                              + (ADDR_W'(fresh_left_r[cls_r]) << (MIN_SHIFT + int'(cls_r)));
        out_status_nxt        = STATUS_ALLOC;
      end
    end else begin
      priority if (addr_r[PAGE_SHIFT-1:0] == '0) begin
        out_status_nxt = STATUS_IGNORED;
      end else if (int'(page_idx) >= PAGES) begin
        out_status_nxt = STATUS_IGNORED;
      end else if (int'(owner) >= CLASSES) begin
        out_status_nxt = STATUS_IGNORED;
      end else if ((addr_r & align_mask) != '0) begin
        out_status_nxt = STATUS_IGNORED;
      end else begin
        link_we               = exec_fire;
        link_wdata            = head_valid_r[cls_f] ? head_addr_r[cls_f] : '0;
        head_addr_nxt[cls_f]  = addr_r;
        head_valid_nxt[cls_f] = 1'b1;
        out_status_nxt        = STATUS_FREED;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_ch.kind;
      cls_r     <= cls_in;
      too_big_r <= too_big_in;
      addr_r    <= in_ch.address;
    end
    if (exec_fire) begin
      head_addr_r  <= head_addr_nxt;
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      head_valid_r <= '0;
      next_page_r  <= NEXT_W'(CLASSES);
      for (int i = 0; i < CLASSES; i++) begin
        fresh_page_r[i] <= PAGE_W'(i);
        fresh_left_r[i] <= slots_after_header(i);
      end
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        out_valid_r  <= 1'b1;
        head_valid_r <= head_valid_nxt;
        fresh_page_r <= fresh_page_nxt;
        fresh_left_r <= fresh_left_nxt;
        next_page_r  <= next_page_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `SCSA_ASSERT_NEXT(a_accept_to_exec, in_fire, state_r == ST_EXEC)
  `SCSA_ASSERT_NEXT(a_exec_loads_out, exec_fire, out_valid_r)
  `SCSA_ASSERT_IMPL(a_alloc_nonzero, out_valid_r && out_status_r == STATUS_ALLOC, out_addr_r != '0)
  `SCSA_ASSERT_IMPL(a_other_zero, out_valid_r && out_status_r != STATUS_ALLOC, out_addr_r == '0)
  `SCSA_ASSERT_IMPL(a_page_bound, state_r == ST_IDLE, int'(next_page_r) <= PAGE_LIMIT)

endmodule

### design/scsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
